@@ sv/esc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the sensor compensation pipeline.
// No dependencies; used by env_sensor_compensation and esc_checker.

package esc_pkg;

   // Divider geometry: one 64-bit quotient, a fixed number of bits per stage.
   localparam int DIVIDEND_W         = 64;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = DIVIDEND_W / DIV_BITS_PER_STAGE;

   // Twelve front stages, the divider, six back stages; then the result register.
   localparam int PIPE_DEPTH  = DIV_STAGES + 18;
   localparam int RSP_LATENCY = PIPE_DEPTH + 1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CALIB_T      = 3'd0;
   localparam logic [2:0] CSR_CALIB_P_LOW  = 3'd1;
   localparam logic [2:0] CSR_CALIB_P_HIGH = 3'd2;
   localparam logic [2:0] CSR_CALIB_P9_H   = 3'd3;
   localparam logic [2:0] CSR_CALIB_H45    = 3'd4;

   // Compensation constants.
   localparam int T_FINE_P_OFS   = 128000;
   localparam int T_FINE_H_OFS   = 76800;
   localparam int PRESS_ADC_FULL = 1048576;
   localparam int PRESS_SCALE    = 3125;
   localparam int HUM_CLAMP      = 419430400;
   localparam int HUM_G_OFS      = 2097152;
   localparam int HUM_U_ROUND    = 16384;
   localparam int HUM_R_OFS      = 32768;
   localparam int HUM_G_ROUND    = 8192;

   // Partial products of a 64-bit word times a 17-bit signed coefficient.
   typedef struct packed {
      logic signed [49:0] lo;
      logic [31:0]        hi;
   } mulc_pp_type;

   // Partial products of the low 64 bits of a 64 x 64 product.
   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] lh;
      logic [31:0] hl;
   } mul_pp_type;

   // Side results that travel alongside the pressure word.
   typedef struct packed {
      logic signed [23:0] temp;
      logic [6:0]         hum;
      logic               fault;
   } meta_type;

   // One divider stage: shifting dividend/quotient word, partial remainder.
   typedef struct packed {
      logic [63:0] work;
      logic [30:0] rem;
      logic [30:0] dmag;
      logic        qneg;
      meta_type    meta;
   } div_stage_type;

   function automatic mulc_pp_type mulc_pp(input logic [63:0] a, input logic signed [16:0] c);
      mulc_pp_type r;
      r.lo = 50'($signed({1'b0, a[31:0]}) * c);
      r.hi = 32'($signed(a[63:32]) * c);
      return r;
   endfunction

   function automatic logic [63:0] mulc_sum(input mulc_pp_type p);
      return 64'(p.lo) + {p.hi, 32'b0};
   endfunction

   function automatic mul_pp_type mul_pp(input logic [63:0] a, input logic [63:0] b);
      mul_pp_type r;
      r.ll = 64'(a[31:0]) * 64'(b[31:0]);
      r.lh = 32'(a[31:0] * b[63:32]);
      r.hl = 32'(a[63:32] * b[31:0]);
      return r;
   endfunction

   function automatic logic [63:0] mul_sum(input mul_pp_type p);
      return p.ll + {32'(p.lh + p.hl), 32'b0};
   endfunction

   // Restoring division, a few quotient bits per call.
   function automatic div_stage_type div_step(input div_stage_type x);
      div_stage_type r;
      logic [31:0]   t;
      r = x;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         t = {r.rem, r.work[63]};
         r.work = {r.work[62:0], 1'b0};
         if (t >= {1'b0, r.dmag}) begin
            t = t - {1'b0, r.dmag};
            r.work[0] = 1'b1;
         end
         r.rem = t[30:0];
      end
      return r;
   endfunction

endpackage

@@ sv/env_sensor_compensation.sv @@
// Top level: integer temperature / pressure / humidity compensation pipeline.
// Depends on esc_pkg (types, constants, multiply and divide helpers).
//
//   channel  ports                 handshake               word
//   input    req_*                 start && !busy          raw temperature, pressure, humidity
//   result   rsp_*                 rsp_valid, one cycle    temperature, pressure, humidity, fault
//   config   csr_*                 csr_valid && csr_ready  register index, data
//
// One burst is accepted every cycle; busy stays low.
// Each result passes through the 32-stage radix-4 pressure divider plus the multiply
// stages around it.
// Synchronous reset clears the valid chain and the calibration registers.
// Results cannot be held off, so the pipeline never stalls.

module env_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [19:0]        req_adc_temperature,
   input  logic [19:0]        req_adc_pressure,
   input  logic [15:0]        req_adc_humidity,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_temperature_centi,
   output logic [23:0]        rsp_pressure_pa,
   output logic [6:0]         rsp_humidity_percent,
   output logic               rsp_pressure_fault,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int NDIV = esc_pkg::DIV_STAGES;

   // ---------------- calibration registers ----------------
   logic [47:0] calib_t_ff;
   logic [63:0] calib_p_low_ff;
   logic [63:0] calib_p_high_ff;
   logic [55:0] calib_p9_h_ff;
   logic [23:0] calib_h45_ff;

   logic [esc_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic                           rsp_valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_t_ff      <= '0;
         calib_p_low_ff  <= '0;
         calib_p_high_ff <= '0;
         calib_p9_h_ff   <= '0;
         calib_h45_ff    <= '0;
         vld_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               esc_pkg::CSR_CALIB_T:      calib_t_ff      <= csr_data[47:0];
               esc_pkg::CSR_CALIB_P_LOW:  calib_p_low_ff  <= csr_data;
               esc_pkg::CSR_CALIB_P_HIGH: calib_p_high_ff <= csr_data;
               esc_pkg::CSR_CALIB_P9_H:   calib_p9_h_ff   <= csr_data[55:0];
               esc_pkg::CSR_CALIB_H45:    calib_h45_ff    <= csr_data[23:0];
               default: ;
            endcase
         end
         vld_ff       <= {vld_ff[esc_pkg::PIPE_DEPTH-2:0], start && !busy};
         rsp_valid_ff <= vld_ff[esc_pkg::PIPE_DEPTH-1];
      end
   end

   // coefficients
   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]         h1, h3;
   logic signed [7:0]  h6;
   logic signed [11:0] h4, h5;

   assign t1 = calib_t_ff[15:0];
   assign t2 = $signed(calib_t_ff[31:16]);
   assign t3 = $signed(calib_t_ff[47:32]);
   assign p1 = calib_p_low_ff[15:0];
   assign p2 = $signed(calib_p_low_ff[31:16]);
   assign p3 = $signed(calib_p_low_ff[47:32]);
   assign p4 = $signed(calib_p_low_ff[63:48]);
   assign p5 = $signed(calib_p_high_ff[15:0]);
   assign p6 = $signed(calib_p_high_ff[31:16]);
   assign p7 = $signed(calib_p_high_ff[47:32]);
   assign p8 = $signed(calib_p_high_ff[63:48]);
   assign p9 = $signed(calib_p9_h_ff[15:0]);
   assign h1 = calib_p9_h_ff[23:16];
   assign h2 = $signed(calib_p9_h_ff[39:24]);
   assign h3 = calib_p9_h_ff[47:40];
   assign h6 = $signed(calib_p9_h_ff[55:48]);
   assign h4 = $signed(calib_h45_ff[11:0]);
   assign h5 = $signed(calib_h45_ff[23:12]);

   // ---------------- front stages ----------------
   logic [19:0] s0_adc_t_ff, s0_adc_p_ff;
   logic [15:0] s0_adc_h_ff;
   logic [19:0] adcp_ff [1:7];
   logic [15:0] adch_ff [1:5];
   logic signed [23:0] temp_ff [4:10];

   // s1: linear and square temperature terms
   logic signed [17:0] s1_tdiff, s1_d;
   logic signed [33:0] s1_ta_in, s1_ta_ff;
   logic signed [35:0] s1_dsq;
   logic [31:0]        s1_dd_in, s1_dd_ff;
   always_comb begin
      s1_tdiff = $signed({1'b0, s0_adc_t_ff[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_d     = $signed({2'b0, s0_adc_t_ff[19:4]}) - $signed({2'b0, t1});
      s1_ta_in = s1_tdiff * t2;
      s1_dsq   = s1_d * s1_d;
      s1_dd_in = s1_dsq[31:0];
   end

   // s2
   logic signed [22:0] s2_a_in, s2_a_ff;
   logic signed [36:0] s2_bp_in, s2_bp_ff;
   always_comb begin
      s2_a_in  = 23'(s1_ta_ff >>> 11);
      s2_bp_in = $signed({1'b0, s1_dd_ff[31:12]}) * t3;
   end

   // s3: fine temperature
   logic signed [23:0] s3_tfine_in, s3_tfine_ff;
   assign s3_tfine_in = 24'(s2_a_ff) + 24'(s2_bp_ff >>> 14);

   // s4: output temperature, pressure and humidity offsets
   logic signed [27:0] s4_t5, s4_tsh;
   logic signed [23:0] s4_temp_in;
   logic signed [24:0] s4_x1_in, s4_x1_ff, s4_v_in, s4_v_ff;
   always_comb begin
      s4_t5  = 28'(s3_tfine_ff) * 28'sd5 + 28'sd128;
      s4_tsh = s4_t5 >>> 8;
      if (s4_tsh > 28'sd8388607) begin
         s4_temp_in = 24'sh7FFFFF;
      end else if (s4_tsh < -28'sd8388608) begin
         s4_temp_in = 24'sh800000;
      end else begin
         s4_temp_in = 24'(s4_tsh);
      end
      s4_x1_in = 25'(s3_tfine_ff) - 25'(esc_pkg::T_FINE_P_OFS);
      s4_v_in  = 25'(s3_tfine_ff) - 25'(esc_pkg::T_FINE_H_OFS);
   end

   // s5
   logic signed [49:0] s5_xx_in, s5_xx_ff;
   logic signed [40:0] s5_x1p5_in, s5_x1p5_ff, s5_x1p2_in, s5_x1p2_ff;
   logic signed [36:0] s5_h5v_in, s5_h5v_ff;
   logic signed [32:0] s5_vh6_in, s5_vh6_ff;
   logic signed [33:0] s5_vh3_in, s5_vh3_ff;
   always_comb begin
      s5_xx_in   = s4_x1_ff * s4_x1_ff;
      s5_x1p5_in = s4_x1_ff * p5;
      s5_x1p2_in = s4_x1_ff * p2;
      s5_h5v_in  = h5 * s4_v_ff;
      s5_vh6_in  = s4_v_ff * h6;
      s5_vh3_in  = s4_v_ff * $signed({1'b0, h3});
   end

   // s6
   logic signed [63:0] s6_xxp6_in, s6_xxp6_ff, s6_xxp3_in, s6_xxp3_ff;
   logic signed [40:0] s6_x1p5_ff, s6_x1p2_ff;
   logic [31:0]        s6_ub;
   logic signed [31:0] s6_sh, s6_r;
   logic signed [31:0] s6_u_in, s6_u_ff, s6_sr_in, s6_sr_ff;
   always_comb begin
      s6_xxp6_in = 64'(s5_xx_ff * p6);
      s6_xxp3_in = 64'(s5_xx_ff * p3);
      s6_ub      = 32'({adch_ff[5], 14'b0}) - (32'(h4) << 20) - s5_h5v_ff[31:0]
                   + 32'(esc_pkg::HUM_U_ROUND);
      s6_u_in    = $signed(s6_ub) >>> 15;
      s6_sh      = $signed(s5_vh6_ff[31:0]) >>> 10;
      s6_r       = ($signed(s5_vh3_ff[31:0]) >>> 11) + 32'(esc_pkg::HUM_R_OFS);
      s6_sr_in   = 32'(s6_sh * s6_r);
   end

   // s7
   logic signed [63:0] s7_x2_in, s7_x2_ff, s7_y_in, s7_y_ff;
   logic signed [31:0] s7_g, s7_gh2_in, s7_gh2_ff, s7_u_ff;
   always_comb begin
      s7_x2_in  = s6_xxp6_ff + (64'(s6_x1p5_ff) << 17) + (64'(p4) << 35);
      s7_y_in   = (s6_xxp3_ff >>> 8) + (64'(s6_x1p2_ff) << 12);
      s7_g      = (s6_sr_ff >>> 10) + 32'(esc_pkg::HUM_G_OFS);
      s7_gh2_in = 32'(s7_g * h2);
   end

   // s8
   logic [20:0]        s8_pa;
   logic signed [63:0] s8_yp_in, s8_yp_ff, s8_num_in, s8_num_ff;
   logic signed [31:0] s8_g2, s8_vv_in, s8_vv_ff;
   always_comb begin
      s8_yp_in  = s7_y_ff + (64'sd1 <<< 47);
      s8_pa     = 21'(esc_pkg::PRESS_ADC_FULL) - {1'b0, adcp_ff[7]};
      s8_num_in = (64'(s8_pa) << 31) - s7_x2_ff;
      s8_g2     = $signed(s7_gh2_ff + 32'(esc_pkg::HUM_G_ROUND)) >>> 14;
      s8_vv_in  = 32'(s7_u_ff * s8_g2);
   end

   // s9
   esc_pkg::mulc_pp_type s9_ypp_in, s9_ypp_ff, s9_nump_in, s9_nump_ff;
   logic signed [31:0]   s9_t15, s9_sqp_in, s9_sqp_ff, s9_vv_ff;
   always_comb begin
      s9_ypp_in  = esc_pkg::mulc_pp(s8_yp_ff, $signed({1'b0, p1}));
      s9_nump_in = esc_pkg::mulc_pp(s8_num_ff, 17'(esc_pkg::PRESS_SCALE));
      s9_t15     = s8_vv_ff >>> 15;
      s9_sqp_in  = 32'(s9_t15 * s9_t15);
   end

   // s10: divisor and dividend
   logic [63:0]        s10_divf;
   logic signed [30:0] s10_div_in, s10_div_ff;
   logic signed [63:0] s10_numw_in, s10_numw_ff;
   logic signed [31:0] s10_sqh1_in, s10_sqh1_ff, s10_vv_ff;
   always_comb begin
      s10_divf    = esc_pkg::mulc_sum(s9_ypp_ff);
      s10_div_in  = $signed(s10_divf[63:33]);
      s10_numw_in = esc_pkg::mulc_sum(s9_nump_ff);
      s10_sqh1_in = 32'((s9_sqp_ff >>> 7) * $signed({1'b0, h1}));
   end

   // s11: sign and magnitude for the divider, final humidity
   esc_pkg::div_stage_type s11_in, s11_ff;
   logic signed [31:0]     s11_hv, s11_hc;
   always_comb begin
      s11_hv = $signed(s10_vv_ff - 32'(s10_sqh1_ff >>> 4));
      if (s11_hv < 32'sd0) begin
         s11_hc = '0;
      end else if (s11_hv > 32'(esc_pkg::HUM_CLAMP)) begin
         s11_hc = 32'(esc_pkg::HUM_CLAMP);
      end else begin
         s11_hc = s11_hv;
      end
      s11_in.work       = s10_numw_ff[63] ? 64'(-s10_numw_ff) : s10_numw_ff;
      s11_in.rem        = '0;
      s11_in.dmag       = s10_div_ff[30] ? 31'(-s10_div_ff) : s10_div_ff;
      s11_in.qneg       = s10_numw_ff[63] ^ s10_div_ff[30];
      s11_in.meta.temp  = temp_ff[10];
      s11_in.meta.hum   = s11_hc[28:22];
      s11_in.meta.fault = (s10_div_ff == 31'sd0);
   end

   // ---------------- divider ----------------
   esc_pkg::div_stage_type d_ff [0:NDIV-1];

   // ---------------- back stages ----------------
   logic signed [63:0]   ep_ff [0:4];
   logic signed [63:0]   ec2_ff [2:4];
   esc_pkg::meta_type    emeta_ff [0:5];
   logic signed [63:0]   e0_p_in;
   logic signed [63:0]   e1_q;
   esc_pkg::mul_pp_type  e1_qq_pp_in, e1_qq_pp_ff;
   esc_pkg::mulc_pp_type e1_p8_pp_in, e1_p8_pp_ff;
   logic [63:0]          e2_qq_in, e2_qq_ff;
   logic signed [63:0]   e2_c2_in;
   esc_pkg::mulc_pp_type e3_p9_pp_in, e3_p9_pp_ff;
   logic signed [63:0]   e4_c1_in, e4_c1_ff;
   logic signed [63:0]   e5_sm_in, e5_sm_ff;
   logic signed [63:0]   r_pr;
   logic [23:0]          r_press_in, r_press_ff;
   esc_pkg::meta_type    r_meta_ff;

   always_comb begin
      e0_p_in     = d_ff[NDIV-1].qneg ? 64'(-d_ff[NDIV-1].work) : d_ff[NDIV-1].work;
      e1_q        = ep_ff[0] >>> 13;
      e1_qq_pp_in = esc_pkg::mul_pp(e1_q, e1_q);
      e1_p8_pp_in = esc_pkg::mulc_pp(ep_ff[0], 17'(p8));
      e2_qq_in    = esc_pkg::mul_sum(e1_qq_pp_ff);
      e2_c2_in    = $signed(esc_pkg::mulc_sum(e1_p8_pp_ff)) >>> 19;
      e3_p9_pp_in = esc_pkg::mulc_pp(e2_qq_ff, 17'(p9));
      e4_c1_in    = $signed(esc_pkg::mulc_sum(e3_p9_pp_ff)) >>> 25;
      e5_sm_in    = ep_ff[4] + e4_c1_ff + ec2_ff[4];
      r_pr        = (e5_sm_ff >>> 8) + (64'(p7) << 4);
      r_press_in  = emeta_ff[5].fault ? 24'd0 : r_pr[31:8];
   end

   // payload registers: no reset, they load every cycle
   always_ff @(posedge clock) begin
      s0_adc_t_ff <= req_adc_temperature;
      s0_adc_p_ff <= req_adc_pressure;
      s0_adc_h_ff <= req_adc_humidity;
      adcp_ff[1]  <= s0_adc_p_ff;
      adch_ff[1]  <= s0_adc_h_ff;
      for (int i = 2; i <= 7; i++) adcp_ff[i] <= adcp_ff[i-1];
      for (int i = 2; i <= 5; i++) adch_ff[i] <= adch_ff[i-1];
      temp_ff[4] <= s4_temp_in;
      for (int i = 5; i <= 10; i++) temp_ff[i] <= temp_ff[i-1];

      s1_ta_ff    <= s1_ta_in;
      s1_dd_ff    <= s1_dd_in;
      s2_a_ff     <= s2_a_in;
      s2_bp_ff    <= s2_bp_in;
      s3_tfine_ff <= s3_tfine_in;
      s4_x1_ff    <= s4_x1_in;
      s4_v_ff     <= s4_v_in;
      s5_xx_ff    <= s5_xx_in;
      s5_x1p5_ff  <= s5_x1p5_in;
      s5_x1p2_ff  <= s5_x1p2_in;
      s5_h5v_ff   <= s5_h5v_in;
      s5_vh6_ff   <= s5_vh6_in;
      s5_vh3_ff   <= s5_vh3_in;
      s6_xxp6_ff  <= s6_xxp6_in;
      s6_xxp3_ff  <= s6_xxp3_in;
      s6_x1p5_ff  <= s5_x1p5_ff;
      s6_x1p2_ff  <= s5_x1p2_ff;
      s6_u_ff     <= s6_u_in;
      s6_sr_ff    <= s6_sr_in;
      s7_x2_ff    <= s7_x2_in;
      s7_y_ff     <= s7_y_in;
      s7_gh2_ff   <= s7_gh2_in;
      s7_u_ff     <= s6_u_ff;
      s8_yp_ff    <= s8_yp_in;
      s8_num_ff   <= s8_num_in;
      s8_vv_ff    <= s8_vv_in;
      s9_ypp_ff   <= s9_ypp_in;
      s9_nump_ff  <= s9_nump_in;
      s9_sqp_ff   <= s9_sqp_in;
      s9_vv_ff    <= s8_vv_ff;
      s10_div_ff  <= s10_div_in;
      s10_numw_ff <= s10_numw_in;
      s10_sqh1_ff <= s10_sqh1_in;
      s10_vv_ff   <= s9_vv_ff;
      s11_ff      <= s11_in;

      d_ff[0] <= esc_pkg::div_step(s11_ff);
      for (int i = 1; i < NDIV; i++) d_ff[i] <= esc_pkg::div_step(d_ff[i-1]);

      ep_ff[0]    <= e0_p_in;
      emeta_ff[0] <= d_ff[NDIV-1].meta;
      for (int i = 1; i <= 4; i++) ep_ff[i] <= ep_ff[i-1];
      for (int i = 1; i <= 5; i++) emeta_ff[i] <= emeta_ff[i-1];
      e1_qq_pp_ff <= e1_qq_pp_in;
      e1_p8_pp_ff <= e1_p8_pp_in;
      e2_qq_ff    <= e2_qq_in;
      ec2_ff[2]   <= e2_c2_in;
      ec2_ff[3]   <= ec2_ff[2];
      ec2_ff[4]   <= ec2_ff[3];
      e3_p9_pp_ff <= e3_p9_pp_in;
      e4_c1_ff    <= e4_c1_in;
      e5_sm_ff    <= e5_sm_in;
      r_press_ff  <= r_press_in;
      r_meta_ff   <= emeta_ff[5];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = r_meta_ff.temp;
   assign rsp_pressure_pa       = r_press_ff;
   assign rsp_humidity_percent  = r_meta_ff.hum;
   assign rsp_pressure_fault    = r_meta_ff.fault;

endmodule

@@ sv/esc_checker.sv @@
// Port-level checks for env_sensor_compensation, attached by bind.
// Depends on esc_pkg for the fixed result latency.

module esc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [23:0] rsp_pressure_pa,
   input logic [6:0]  rsp_humidity_percent,
   input logic        rsp_pressure_fault
);

   // every accepted word yields exactly one result at the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(esc_pkg::RSP_LATENCY) rsp_valid)
      else $error("accepted word produced no result");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, esc_pkg::RSP_LATENCY))
      else $error("result without matching accepted word");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pressure_fault) |-> (rsp_pressure_pa == 24'd0))
      else $error("pressure not zero on divisor fault");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity_percent <= 7'd100))
      else $error("humidity above 100 percent");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_pressure_pa      (rsp_pressure_pa),
   .rsp_humidity_percent (rsp_humidity_percent),
   .rsp_pressure_fault   (rsp_pressure_fault)
);
